// ===== hw/rtl/box_and_label_overlay_macros.svh =====
// Assertion macros used by the overlay checker.
`ifndef BOX_AND_LABEL_OVERLAY_MACROS_SVH
`define BOX_AND_LABEL_OVERLAY_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define BAL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/bal_pkg.sv =====
// Types, constants and helper functions for the box and label overlay.
package bal_pkg;

  localparam int PIX_W   = 16;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int CRD_W   = 12;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 16;

  // Label geometry
  localparam int LABEL_W    = 74;
  localparam int LABEL_H    = 18;
  localparam int LABEL_PAD  = 2;
  localparam int CHAR_STEP  = 12;
  localparam int CHAR_COUNT = 6;
  localparam int FONT_W     = 5;
  localparam int FONT_H     = 7;
  localparam logic [PIX_W-1:0] LABEL_BG = 16'h0000;

  // 5x7 glyphs spelling TARGET, one row per entry, MSB is the leftmost dot
  localparam logic [FONT_W-1:0] FONT_ROWS [CHAR_COUNT][FONT_H] = '{
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},  // T
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},  // A
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},  // R
    '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},  // G
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},  // E
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}   // T
  };

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_BOX_A_X    = 3'd0,
    REG_BOX_A_Y    = 3'd1,
    REG_BOX_B_X    = 3'd2,
    REG_BOX_B_Y    = 3'd3,
    REG_BOX_COLOR  = 3'd4,
    REG_LABEL_X    = 3'd5,
    REG_LABEL_Y    = 3'd6,
    REG_OVL_ENABLE = 3'd7
  } cfg_reg_t;

  // Derived drawing geometry, recomputed from the registers every cycle
  typedef struct packed {
    logic             box_on;    // box enabled and at least partly in frame
    logic             ring1_on;  // inner ring is not empty
    logic [CRD_W-1:0] bx1;
    logic [CRD_W-1:0] bx2;
    logic [CRD_W-1:0] by1;
    logic [CRD_W-1:0] by2;
    logic [CRD_W-1:0] ix1;
    logic [CRD_W-1:0] ix2;
    logic [CRD_W-1:0] iy1;
    logic [CRD_W-1:0] iy2;
    logic [PIX_W-1:0] box_color;
    logic             label_on;
    logic [CRD_W-1:0] lx;
    logic [CRD_W-1:0] ly;
  } geom_t;

  // Signed clamp on 13-bit values
  function automatic logic signed [CRD_W:0] clamp13(
    input logic signed [CRD_W:0] v,
    input logic signed [CRD_W:0] lo,
    input logic signed [CRD_W:0] hi
  );
    logic signed [CRD_W:0] res;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Pixel lies on the outline of rectangle [l,rt] x [tp,bt]
  function automatic logic ring_hit(
    input logic [CRD_W-1:0] c,
    input logic [CRD_W-1:0] r,
    input logic [CRD_W-1:0] l,
    input logic [CRD_W-1:0] rt,
    input logic [CRD_W-1:0] tp,
    input logic [CRD_W-1:0] bt
  );
    logic horiz;
    logic vert;
    horiz = (r == tp || r == bt) && c >= l && c <= rt;
    vert  = (c == l || c == rt) && r >= tp && r <= bt;
    return horiz || vert;
  endfunction

  // Glyph dot at offset (dx, dy) from the text origin, font doubled in scale
  function automatic logic glyph_dot(
    input logic [6:0] dx,
    input logic [3:0] dy
  );
    logic       dot;
    logic [6:0] char_off;
    logic [2:0] fcol;
    dot      = 1'b0;
    char_off = '0;
    fcol     = '0;
    for (int k = 0; k < CHAR_COUNT; k++) begin
      if (dx >= 7'(k * CHAR_STEP) && dx < 7'(k * CHAR_STEP + 2 * FONT_W)) begin
        char_off = dx - 7'(k * CHAR_STEP);
        fcol     = 3'(FONT_W - 1) - char_off[3:1];
        dot      = FONT_ROWS[k][dy[3:1]][fcol];
      end
    end
    return dot;
  endfunction

endpackage

// ===== hw/rtl/bal_geom.sv =====
// Configuration registers and registered box and label geometry.
module bal_geom
  import bal_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_data,
  output geom_t              geom
);

  localparam int MAXX = (FRAME_WIDTH > LABEL_W) ? FRAME_WIDTH - LABEL_W : 0;
  localparam int MAXY = (FRAME_HEIGHT > LABEL_H) ? FRAME_HEIGHT - LABEL_H : 0;
  localparam logic signed [CRD_W:0] FW_S   = (CRD_W+1)'(FRAME_WIDTH);
  localparam logic signed [CRD_W:0] FH_S   = (CRD_W+1)'(FRAME_HEIGHT);
  localparam logic signed [CRD_W:0] MAXX_S = (CRD_W+1)'(MAXX);
  localparam logic signed [CRD_W:0] MAXY_S = (CRD_W+1)'(MAXY);
  localparam logic signed [CRD_W:0] ZERO_S = '0;
  localparam logic signed [CRD_W:0] ONE_S  = (CRD_W+1)'(1);

  logic [CRD_W-1:0] ax_r, ay_r, bx_r, by_r, anc_x_r, anc_y_r;
  logic [PIX_W-1:0] color_r;
  logic [1:0]       en_r;
  geom_t            geom_r, geom_nxt;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r    <= '0;
      ay_r    <= '0;
      bx_r    <= '0;
      by_r    <= '0;
      color_r <= 16'hFFFF;
      anc_x_r <= '0;
      anc_y_r <= '0;
      en_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BOX_A_X:    ax_r    <= cfg_data[CRD_W-1:0];
        REG_BOX_A_Y:    ay_r    <= cfg_data[CRD_W-1:0];
        REG_BOX_B_X:    bx_r    <= cfg_data[CRD_W-1:0];
        REG_BOX_B_Y:    by_r    <= cfg_data[CRD_W-1:0];
        REG_BOX_COLOR:  color_r <= cfg_data[PIX_W-1:0];
        REG_LABEL_X:    anc_x_r <= cfg_data[CRD_W-1:0];
        REG_LABEL_Y:    anc_y_r <= cfg_data[CRD_W-1:0];
        REG_OVL_ENABLE: en_r    <= cfg_data[1:0];
        default:        en_r    <= en_r;
      endcase
    end
  end

  // Sort, clamp and place; sign-extend to 13 bits first
  always_comb begin
    logic signed [CRD_W:0] ax, ay, bx, by, ancx, ancy;
    logic signed [CRD_W:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [CRD_W:0] x1c, x2c, y1c, y2c;
    logic signed [CRD_W:0] lx, ly_a, ly;
    logic                  outside;
    ax   = {ax_r[CRD_W-1], ax_r};
    ay   = {ay_r[CRD_W-1], ay_r};
    bx   = {bx_r[CRD_W-1], bx_r};
    by   = {by_r[CRD_W-1], by_r};
    ancx = {anc_x_r[CRD_W-1], anc_x_r};
    ancy = {anc_y_r[CRD_W-1], anc_y_r};

    x_lo = (ax > bx) ? bx : ax;
    x_hi = (ax > bx) ? ax : bx;
    y_lo = (ay > by) ? by : ay;
    y_hi = (ay > by) ? ay : by;
    outside = (x_hi < ZERO_S) || (y_hi < ZERO_S) || (x_lo >= FW_S) || (y_lo >= FH_S);

    x1c = clamp13(x_lo, ZERO_S, FW_S - ONE_S);
    x2c = clamp13(x_hi, ZERO_S, FW_S - ONE_S);
    y1c = clamp13(y_lo, ZERO_S, FH_S - ONE_S);
    y2c = clamp13(y_hi, ZERO_S, FH_S - ONE_S);

    lx   = clamp13(ancx, ZERO_S, MAXX_S);
    ly_a = ancy - (CRD_W+1)'(LABEL_H);
    ly   = (ly_a < ZERO_S) ? clamp13(ancy, ZERO_S, MAXY_S) : ly_a;

    geom_nxt.box_on    = en_r[0] && !outside;
    geom_nxt.ring1_on  = (x1c + ONE_S <= x2c - ONE_S) && (y1c + ONE_S <= y2c - ONE_S);
    geom_nxt.bx1       = x1c[CRD_W-1:0];
    geom_nxt.bx2       = x2c[CRD_W-1:0];
    geom_nxt.by1       = y1c[CRD_W-1:0];
    geom_nxt.by2       = y2c[CRD_W-1:0];
    geom_nxt.ix1       = CRD_W'(x1c + ONE_S);
    geom_nxt.ix2       = CRD_W'(x2c - ONE_S);
    geom_nxt.iy1       = CRD_W'(y1c + ONE_S);
    geom_nxt.iy2       = CRD_W'(y2c - ONE_S);
    geom_nxt.box_color = color_r;
    geom_nxt.label_on  = en_r[1];
    geom_nxt.lx        = lx[CRD_W-1:0];
    geom_nxt.ly        = ly[CRD_W-1:0];
  end

  // Geometry register: follows the config registers in the next cycle
  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

// ===== hw/rtl/bal_pixel.sv =====
// Per-pixel datapath: input register, box and label tests, output register.
module bal_pixel
  import bal_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240,
  parameter int TEXT_COLOR   = 63488
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  logic [PIX_W-1:0] in_pix,
  input  logic [COL_W-1:0] in_col,
  input  logic [ROW_W-1:0] in_row,
  input  geom_t            geom,
  output logic             out_vld,
  output logic [PIX_W-1:0] out_pix
);

  logic             in_vld_r;
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             out_vld_r;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pix_r <= in_pix;
      col_r <= in_col;
      row_r <= in_row;
    end
  end

  // Overlay decision; label is drawn over the box
  always_comb begin
    logic [CRD_W-1:0] c, r;
    logic [CRD_W-1:0] offx, offy;
    logic             in_frame, box_hit, in_label, in_text, dot;
    c = {{(CRD_W-COL_W){1'b0}}, col_r};
    r = {{(CRD_W-ROW_W){1'b0}}, row_r};
    // 13-bit compare so a frame size of 4096 still fits
    in_frame = ({1'b0, c} < (CRD_W+1)'(FRAME_WIDTH)) &&
               ({1'b0, r} < (CRD_W+1)'(FRAME_HEIGHT));

    box_hit = geom.box_on &&
              (ring_hit(c, r, geom.bx1, geom.bx2, geom.by1, geom.by2) ||
               (geom.ring1_on &&
                ring_hit(c, r, geom.ix1, geom.ix2, geom.iy1, geom.iy2)));

    offx     = c - geom.lx;
    offy     = r - geom.ly;
    in_label = (c >= geom.lx) && (offx < CRD_W'(LABEL_W)) &&
               (r >= geom.ly) && (offy < CRD_W'(LABEL_H));
    in_text  = (offx >= CRD_W'(LABEL_PAD)) && (offy >= CRD_W'(LABEL_PAD)) &&
               (offy < CRD_W'(LABEL_PAD + 2 * FONT_H));
    dot      = glyph_dot(7'(offx - CRD_W'(LABEL_PAD)), 4'(offy - CRD_W'(LABEL_PAD)));

    out_pix_nxt = pix_r;
    if (in_frame) begin
      if (box_hit) begin
        out_pix_nxt = geom.box_color;
      end
      if (geom.label_on && in_label) begin
        out_pix_nxt = (in_text && dot) ? PIX_W'(TEXT_COLOR) : LABEL_BG;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_pix = out_pix_r;

endmodule

// ===== hw/rtl/box_and_label_overlay.sv =====
// Top level of the box and label overlay for an RGB565 pixel stream.
//
// Usage:
//   Pixel channel: drive in_pixel_in, in_pixel_column and in_pixel_row with
//   start high; the item is taken at any rising edge where busy is low.
//   busy is high only during reset and the cycle after it, so one pixel
//   can be taken every clock.
//   Result channel: out_valid strobes for one cycle with out_pixel_out.
//   Each result passes the input register, then the result register;
//   throughput is one item per clock while busy is low. The receiver
//   has no way to stall, so results are presented once and must be
//   captured on the strobe.
//   Config channel: cfg_addr selects the register, cfg_data carries its
//   value; a write lands on an edge with cfg_valid and cfg_ready high.
//   Write only while no pixels are in flight; the derived geometry
//   follows in the cycle after the write.
//   Reset (synchronous, active low) clears the pipeline valids and loads
//   the register defaults: box white, both overlays disabled.
module box_and_label_overlay
  import bal_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240,
  parameter int TEXT_COLOR   = 63488
) (
  input  logic               clk,
  input  logic               rst_n,
  // pixel input
  input  logic               start,
  output logic               busy,
  input  logic [PIX_W-1:0]   in_pixel_in,
  input  logic [COL_W-1:0]   in_pixel_column,
  input  logic [ROW_W-1:0]   in_pixel_row,
  // pixel result
  output logic               out_valid,
  output logic [PIX_W-1:0]   out_pixel_out,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_data
);

  logic  busy_r;
  geom_t geom;

  // Held busy through reset and the cycle after it while geometry settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  bal_geom #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .geom    (geom)
  );

  bal_pixel #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .TEXT_COLOR  (TEXT_COLOR)
  ) u_pixel (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_take(start && !busy_r),
    .in_pix (in_pixel_in),
    .in_col (in_pixel_column),
    .in_row (in_pixel_row),
    .geom   (geom),
    .out_vld(out_valid),
    .out_pix(out_pixel_out)
  );

endmodule

// ===== hw/rtl/bal_checker.sv =====
// Port-level checker for the overlay, bound to the top level.
`include "box_and_label_overlay_macros.svh"

module bal_checker #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_pixel_in,
  input logic [8:0]  in_pixel_column,
  input logic [7:0]  in_pixel_row,
  input logic        out_valid,
  input logic [15:0] out_pixel_out
);

  // Every accepted item gives exactly one strobe, after the input and result registers
  `BAL_ASSERT(a_item_gives_result, (start && !busy) |-> ##2 out_valid, "accepted item lost")
  `BAL_ASSERT(a_result_has_item, out_valid |-> $past(start && !busy, 2), "result without item")

  // Pixels outside the frame pass through untouched
  `BAL_ASSERT(a_outside_passes, (start && !busy && (32'(in_pixel_column) >= FRAME_WIDTH || 32'(in_pixel_row) >= FRAME_HEIGHT)) |-> ##2 (out_pixel_out == $past(in_pixel_in, 2)), "outside pixel altered")

  // Reset flushes the pipeline and holds off new items
  `BAL_ASSERT_RST(a_reset_flush, !rst_n |=> (!out_valid && busy), "reset did not flush")

endmodule

bind box_and_label_overlay bal_checker #(
  .FRAME_WIDTH (FRAME_WIDTH),
  .FRAME_HEIGHT(FRAME_HEIGHT)
) u_bal_checker (.*);

// ===== tb/box_and_label_overlay_tb.sv =====
// Self-checking testbench for the box and label overlay pixel pipeline.
`timescale 1ns / 1ps

module box_and_label_overlay_tb;
  import bal_pkg::*;

  // Frame and text setup of the instance under test (its defaults)
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam logic [PIX_W-1:0] TEXT_COLOR = 16'hF800;

  // Result register follows the input register; geometry follows a write in the next cycle
  localparam int PIPE_LATENCY = 2;
  localparam int CFG_SETTLE   = 2;
  localparam int REG_COUNT    = 1 << CFG_A_W;

  localparam int ITEMS_PER_PHASE = 85;
  localparam int RANDOM_PHASES   = 12;
  localparam int QUIET_PHASES    = 2;

  // Enable register bits and settings
  localparam int EN_BOX_BIT   = 0;
  localparam int EN_LABEL_BIT = 1;
  localparam logic [1:0] ENABLE_NONE  = 2'b00;
  localparam logic [1:0] ENABLE_BOX   = 2'b01;
  localparam logic [1:0] ENABLE_LABEL = 2'b10;
  localparam logic [1:0] ENABLE_BOTH  = 2'b11;

  typedef enum logic [1:0] {
    LABEL_MISS,
    LABEL_BACK,
    LABEL_GLYPH
  } label_hit_t;

  typedef struct packed {
    logic [PIX_W-1:0] want_pixel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } overlay_item_t;

  // One write word per register, indexed by cfg_reg_t
  typedef logic [REG_COUNT-1:0][CFG_D_W-1:0] cfg_words_t;

  logic               clk;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic [PIX_W-1:0]   in_pixel_in     = '0;
  logic [COL_W-1:0]   in_pixel_column = '0;
  logic [ROW_W-1:0]   in_pixel_row    = '0;
  logic               out_valid;
  logic [PIX_W-1:0]   out_pixel_out;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic [CFG_A_W-1:0] cfg_addr        = '0;
  logic [CFG_D_W-1:0] cfg_data        = '0;

  // Shadow copy of the overlay registers, at their reset values
  int               cur_box_ax    = 0;
  int               cur_box_ay    = 0;
  int               cur_box_bx    = 0;
  int               cur_box_by    = 0;
  logic [PIX_W-1:0] cur_box_color = 16'hFFFF;
  int               cur_label_ax  = 0;
  int               cur_label_ay  = 0;
  logic [1:0]       cur_enable    = ENABLE_NONE;

  overlay_item_t pending_pixels[$];
  overlay_item_t result_head;
  int            error_count = 0;

  box_and_label_overlay u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_in     (in_pixel_in),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .out_valid       (out_valid),
    .out_pixel_out   (out_pixel_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Two-pixel outline of the sorted, frame-clamped box
  function automatic bit box_outline_hit(int c, int r);
    int x1, x2, y1, y2;
    x1 = (cur_box_ax < cur_box_bx) ? cur_box_ax : cur_box_bx;
    x2 = (cur_box_ax < cur_box_bx) ? cur_box_bx : cur_box_ax;
    y1 = (cur_box_ay < cur_box_by) ? cur_box_ay : cur_box_by;
    y2 = (cur_box_ay < cur_box_by) ? cur_box_by : cur_box_ay;
    if (x2 < 0 || y2 < 0 || x1 >= FRAME_WIDTH || y1 >= FRAME_HEIGHT) return 1'b0;
    x1 = clamp_int(x1, 0, FRAME_WIDTH - 1);
    x2 = clamp_int(x2, 0, FRAME_WIDTH - 1);
    y1 = clamp_int(y1, 0, FRAME_HEIGHT - 1);
    y2 = clamp_int(y2, 0, FRAME_HEIGHT - 1);
    for (int o = 0; o < 2; o++) begin
      // an empty ring ends the outline
      if (x1 + o > x2 - o || y1 + o > y2 - o) return 1'b0;
      if ((r == y1 + o || r == y2 - o) && c >= x1 + o && c <= x2 - o) return 1'b1;
      if ((c == x1 + o || c == x2 - o) && r >= y1 + o && r <= y2 - o) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Top-left corner of the label after clamping
  function automatic void label_origin(output int lx, output int ly);
    int maxx, maxy;
    maxx = (FRAME_WIDTH - LABEL_W < 0) ? 0 : FRAME_WIDTH - LABEL_W;
    maxy = (FRAME_HEIGHT - LABEL_H < 0) ? 0 : FRAME_HEIGHT - LABEL_H;
    lx = clamp_int(cur_label_ax, 0, maxx);
    ly = cur_label_ay - LABEL_H;
    // no room above the anchor: keep the label inside the frame
    if (ly < 0) ly = clamp_int(cur_label_ay, 0, maxy);
  endfunction

  function automatic label_hit_t label_lookup(int c, int r);
    int lx, ly, dx, dy, idx, char_off;
    label_origin(lx, ly);
    if (c < lx || c >= lx + LABEL_W || r < ly || r >= ly + LABEL_H) return LABEL_MISS;
    dx = c - lx - LABEL_PAD;
    dy = r - ly - LABEL_PAD;
    if (dx < 0 || dy < 0 || dy >= 2 * FONT_H) return LABEL_BACK;
    idx      = dx / CHAR_STEP;
    char_off = dx % CHAR_STEP;
    if (idx >= CHAR_COUNT || char_off >= 2 * FONT_W) return LABEL_BACK;
    // each font dot covers 2x2 pixels, MSB is the leftmost dot
    return FONT_ROWS[idx][dy / 2][FONT_W - 1 - char_off / 2] ? LABEL_GLYPH : LABEL_BACK;
  endfunction

  // Expected output pixel; label drawn over the box
  function automatic logic [PIX_W-1:0] overlay_pixel(
    input logic [PIX_W-1:0] pix,
    input logic [COL_W-1:0] col,
    input logic [ROW_W-1:0] row
  );
    logic [PIX_W-1:0] res;
    label_hit_t       hit;
    int               c, r;
    res = pix;
    c   = col;
    r   = row;
    if (c < FRAME_WIDTH && r < FRAME_HEIGHT) begin
      if (cur_enable[EN_BOX_BIT] && box_outline_hit(c, r)) res = cur_box_color;
      if (cur_enable[EN_LABEL_BIT]) begin
        hit = label_lookup(c, r);
        if (hit == LABEL_BACK) res = LABEL_BG;
        else if (hit == LABEL_GLYPH) res = TEXT_COLOR;
      end
    end
    return res;
  endfunction

  // Register words; unused upper bits get random fill
  function automatic cfg_words_t make_cfg(
    int ax, int ay, int bx, int by, logic [PIX_W-1:0] color,
    int lax, int lay, logic [1:0] en
  );
    cfg_words_t words;
    words[REG_BOX_A_X]    = {4'($urandom), 12'(ax)};
    words[REG_BOX_A_Y]    = {4'($urandom), 12'(ay)};
    words[REG_BOX_B_X]    = {4'($urandom), 12'(bx)};
    words[REG_BOX_B_Y]    = {4'($urandom), 12'(by)};
    words[REG_BOX_COLOR]  = color;
    words[REG_LABEL_X]    = {4'($urandom), 12'(lax)};
    words[REG_LABEL_Y]    = {4'($urandom), 12'(lay)};
    words[REG_OVL_ENABLE] = {14'($urandom), en};
    return words;
  endfunction

  // Coordinate mostly near the frame, sometimes anywhere or at the extremes
  function automatic int rand_coord(int span);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? -2048 : 2047;
      1:       return int'($urandom_range(0, 4095)) - 2048;
      default: return int'($urandom_range(0, span + 40)) - 20;
    endcase
  endfunction

  function automatic cfg_words_t random_config();
    int ax, ay, bx, by;
    ax = rand_coord(FRAME_WIDTH);
    ay = rand_coord(FRAME_HEIGHT);
    // now and then a box one to three pixels across
    bx = ($urandom_range(0, 4) == 0) ? clamp_int(ax + $urandom_range(0, 2), -2048, 2047)
                                     : rand_coord(FRAME_WIDTH);
    by = ($urandom_range(0, 4) == 0) ? clamp_int(ay + $urandom_range(0, 2), -2048, 2047)
                                     : rand_coord(FRAME_HEIGHT);
    return make_cfg(ax, ay, bx, by, 16'($urandom), rand_coord(FRAME_WIDTH),
                    rand_coord(FRAME_HEIGHT),
                    ($urandom_range(0, 3) == 0) ? 2'($urandom) : ENABLE_BOTH);
  endfunction

  // Near one edge of the span, or anywhere inside it
  function automatic int near_span(int a, int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if ($urandom_range(0, 1)) return ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 4)) - 2;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic random_pixel_coords(output logic [COL_W-1:0] col, output logic [ROW_W-1:0] row);
    int c, r, lx, ly;
    label_origin(lx, ly);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        c = near_span(cur_box_ax, cur_box_bx);
        r = near_span(cur_box_ay, cur_box_by);
      end
      4, 5, 6: begin
        c = lx + $urandom_range(0, LABEL_W - 1);
        r = ly + $urandom_range(0, LABEL_H - 1);
      end
      default: begin
        c = $urandom_range(0, FRAME_WIDTH - 1);
        r = $urandom_range(0, FRAME_HEIGHT - 1);
      end
    endcase
    col = COL_W'(clamp_int(c, 0, FRAME_WIDTH - 1));
    row = ROW_W'(clamp_int(r, 0, FRAME_HEIGHT - 1));
    // noise over the whole field range, off-frame included
    if ($urandom_range(0, 9) == 0) begin
      col = COL_W'($urandom);
      row = ROW_W'($urandom);
    end
  endtask

  // Send one pixel item; start stays high for a following item
  task automatic send_pixel(
    input logic [PIX_W-1:0] pix,
    input logic [COL_W-1:0] col,
    input logic [ROW_W-1:0] row
  );
    overlay_item_t item;
    in_pixel_in     <= pix;
    in_pixel_column <= col;
    in_pixel_row    <= row;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    item.want_pixel = overlay_pixel(pix, col, row);
    item.col        = col;
    item.row        = row;
    pending_pixels.push_back(item);
  endtask

  // Drain the pipeline
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write all registers in index order while the pipeline is empty
  task automatic apply_config(input cfg_words_t words, input bit gaps);
    cfg_reg_t idx;
    wait_idle();
    for (int i = 0; i < REG_COUNT; i++) begin
      idx = cfg_reg_t'(i);
      cfg_addr  <= idx;
      cfg_data  <= words[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_BOX_A_X:    cur_box_ax    = int'($signed(words[i][CRD_W-1:0]));
        REG_BOX_A_Y:    cur_box_ay    = int'($signed(words[i][CRD_W-1:0]));
        REG_BOX_B_X:    cur_box_bx    = int'($signed(words[i][CRD_W-1:0]));
        REG_BOX_B_Y:    cur_box_by    = int'($signed(words[i][CRD_W-1:0]));
        REG_BOX_COLOR:  cur_box_color = words[i];
        REG_LABEL_X:    cur_label_ax  = int'($signed(words[i][CRD_W-1:0]));
        REG_LABEL_Y:    cur_label_ay  = int'($signed(words[i][CRD_W-1:0]));
        REG_OVL_ENABLE: cur_enable    = words[i][1:0];
        default: ;
      endcase
      if (gaps && $urandom_range(0, 3) == 0) begin
        cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  // Result checker: every strobe matches the oldest pending item
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel_out: expected none, actual %h", out_pixel_out);
        error_count++;
      end else begin
        result_head = pending_pixels.pop_front();
        if (out_pixel_out !== result_head.want_pixel) begin
          $error("pixel_out at column %0d row %0d: expected %h, actual %h",
                 result_head.col, result_head.row, result_head.want_pixel, out_pixel_out);
          error_count++;
        end
      end
    end
  end

  // Defaults: both overlays off, pixels pass through
  task automatic test_passthrough_at_reset();
    send_pixel(16'h0000, 9'd0, 8'd0);
    send_pixel(16'hFFFF, 9'd319, 8'd239);
  endtask

  // Corners given in reverse order, both rings and the interior
  task automatic test_box_outline();
    apply_config(make_cfg(100, 80, 20, 30, 16'h07E0, 0, 0, ENABLE_BOX), 1'b0);
    send_pixel(16'($urandom), 9'd20, 8'd30);
    send_pixel(16'($urandom), 9'd21, 8'd50);
    send_pixel(16'($urandom), 9'd22, 8'd50);
    send_pixel(16'($urandom), 9'd100, 8'd80);
    send_pixel(16'($urandom), 9'd60, 8'd30);
    send_pixel(16'($urandom), 9'd60, 8'd31);
  endtask

  // Clamping to the frame, box wholly outside, one-pixel-wide box
  task automatic test_box_clamp();
    apply_config(make_cfg(-2048, -5, 2047, 100, 16'h001F, 0, 0, ENABLE_BOX), 1'b0);
    send_pixel(16'($urandom), 9'd0, 8'd50);
    send_pixel(16'($urandom), 9'd1, 8'd1);
    send_pixel(16'($urandom), 9'd2, 8'd2);
    apply_config(make_cfg(320, 0, 2047, 239, 16'h001F, 0, 0, ENABLE_BOX), 1'b0);
    send_pixel(16'($urandom), 9'd319, 8'd0);
    apply_config(make_cfg(50, 50, 50, 60, 16'hF81F, 0, 0, ENABLE_BOX), 1'b0);
    send_pixel(16'($urandom), 9'd50, 8'd55);
  endtask

  // Label pinned to the right edge with no room above, then off the frame
  task automatic test_label();
    apply_config(make_cfg(0, 0, 0, 0, 16'hFFFF, 2047, 5, ENABLE_LABEL), 1'b0);
    send_pixel(16'($urandom), 9'd246, 8'd5);
    send_pixel(16'($urandom), 9'd248, 8'd7);
    send_pixel(16'($urandom), 9'd258, 8'd7);
    send_pixel(16'($urandom), 9'd252, 8'd9);
    send_pixel(16'($urandom), 9'd319, 8'd22);
    apply_config(make_cfg(0, 0, 0, 0, 16'hFFFF, -2048, 2047, ENABLE_LABEL), 1'b0);
    send_pixel(16'($urandom), 9'd0, 8'd239);
  endtask

  // Full-frame box with the label on top of it
  task automatic test_label_over_box();
    apply_config(make_cfg(0, 0, 319, 239, 16'h001F, 0, 18, ENABLE_BOTH), 1'b0);
    send_pixel(16'($urandom), 9'd0, 8'd0);
    send_pixel(16'($urandom), 9'd100, 8'd0);
  endtask

  // Off-frame coordinates pass through untouched
  task automatic test_outside_frame();
    apply_config(make_cfg(0, 0, 319, 239, 16'h001F, 0, 18, ENABLE_BOTH), 1'b0);
    send_pixel(16'hFFFF, 9'd320, 8'd0);
    send_pixel(16'h0000, 9'd511, 8'd255);
    send_pixel(16'hA5A5, 9'd0, 8'd240);
  endtask

  // Random phases, each with its own register setting
  task automatic test_random_stream();
    cfg_words_t       words;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)
        words = make_cfg(-2048, -2048, -2048, -2048, 16'h0000, -2048, -2048, ENABLE_BOTH);
      else if (ph == 1)
        words = make_cfg(2047, 2047, 2047, 2047, 16'hFFFF, 2047, 2047, ENABLE_BOTH);
      else if (ph == 2)
        words = make_cfg(-2048, -2048, 2047, 2047, 16'($urandom), 0, 0, ENABLE_BOTH);
      else
        words = random_config();
      apply_config(words, 1'b1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_pixel_coords(col, row);
        send_pixel(16'($urandom), col, row);
        // idle bursts, none in the closing phases
        if (ph < RANDOM_PHASES - QUIET_PHASES && $urandom_range(0, 7) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
      end
    end
  endtask

  // Sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough_at_reset();
    test_box_outline();
    test_box_clamp();
    test_label();
    test_label_over_box();
    test_outside_frame();
    test_random_stream();
    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
